// ===== rtl/core/pse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// Shared widths, reset values and a helper function of the stroke extruder.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int COORD_W_DEF = 24;

  // Half width register: unsigned Q.16, 23 bits.
  localparam int HW_W = 23;
  localparam logic [HW_W-1:0] HW_RESET = 23'd65536;

  // Offsets, projection scalars and projections stay within the half width
  // plus rounding, so two bits over the register width hold them signed.
  localparam int D_W = HW_W + 2;

  // Square root unit: 64-bit radicand, 32-bit root.
  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = 32;
  localparam logic [SQ_IN_W-1:0] SQ_LIM = 64'h7FFF_FFFF_FFFF_FFFF;

  // Configuration register byte addresses.
  localparam logic [2:0] CFG_ADDR_HALF_WIDTH = 3'd0;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/polyline_stroke_extruder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_stroke_extruder
// Extrudes a stream of polyline points into a triangle strip of fixed half
// width, with inner-joint correction, using one multiplier, one serial
// divider and one serial square root under a sequencer.
// ----------------------------------------------------------------------------
//  Port group | Direction | Carries
//  in_*       | sink      | path point x, y; tlast = final point
//  out_*      | source    | strip vertex x, y; tuser = corner, degenerate, run last;
//             |           | tlast = strip end
//  cfg_*      | APB slave | half width register at address 0
//
// A first point is only stored. A later point runs the sequencer, the square
// root and up to eight divider runs; a zero-length segment skips its
// divisions. Reset is synchronous and active low and clears the path state;
// the half width returns to 1.0. Up to eight vertices are buffered and drain
// while the next point is already being worked on; the sequencer only waits
// for the buffer before it writes new vertices.
// ----------------------------------------------------------------------------
module polyline_stroke_extruder import pse_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // point_x, point_y
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]           in_tdata,
  input  logic                                         in_tlast,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // vertex_x, vertex_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]           out_tdata,
  // corner[1:0], degenerate, run_last
  output logic [3:0]                                   out_tuser,
  output logic                                         out_tlast,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  input  logic                                         cfg_psel,
  input  logic                                         cfg_penable,
  input  logic                                         cfg_pwrite,
  input  logic [2:0]                                   cfg_paddr,
  input  logic [31:0]                                  cfg_pwdata,
  output logic [31:0]                                  cfg_prdata,
  output logic                                         cfg_pready
);

  localparam int CW    = COORD_WIDTH;
  localparam int V_W   = CW + 1;
  localparam int MW    = max2(V_W, D_W + 1);
  localparam int PW    = 2 * MW;
  localparam int ACC_W = PW + 1;
  localparam int Q_W   = ACC_W + 2;
  localparam int VX_W  = max2(CW, D_W) + 2;
  localparam int TD_W  = ((2 * CW + 7) / 8) * 8;
  localparam int SQW   = max2(ACC_W, SQ_IN_W);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SQ_A  = 5'd1;
  localparam logic [4:0] ST_SQ_B  = 5'd2;
  localparam logic [4:0] ST_SQ_C  = 5'd3;
  localparam logic [4:0] ST_SQRT  = 5'd4;
  localparam logic [4:0] ST_DX    = 5'd5;
  localparam logic [4:0] ST_DXW   = 5'd6;
  localparam logic [4:0] ST_DY    = 5'd7;
  localparam logic [4:0] ST_DYW   = 5'd8;
  localparam logic [4:0] ST_JOINT = 5'd9;
  localparam logic [4:0] ST_TA    = 5'd10;
  localparam logic [4:0] ST_TB    = 5'd11;
  localparam logic [4:0] ST_PJ    = 5'd12;
  localparam logic [4:0] ST_PA    = 5'd13;
  localparam logic [4:0] ST_PB    = 5'd14;
  localparam logic [4:0] ST_PB2   = 5'd15;
  localparam logic [4:0] ST_PBW   = 5'd16;
  localparam logic [4:0] ST_PC    = 5'd17;
  localparam logic [4:0] ST_PD    = 5'd18;
  localparam logic [4:0] ST_PDW   = 5'd19;
  localparam logic [4:0] ST_PE    = 5'd20;
  localparam logic [4:0] ST_PEW   = 5'd21;
  localparam logic [4:0] ST_PNEXT = 5'd22;
  localparam logic [4:0] ST_BUILD = 5'd23;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_SEG  = 2'd2;

  // Control state
  logic [4:0]      state_r, state_nxt;
  logic [1:0]      seen_r;
  logic [HW_W-1:0] hw_r;
  logic [3:0]      buf_cnt_r;
  logic [2:0]      rd_idx_r;

  // Datapath registers
  logic signed [CW-1:0]    p_x_r, p_y_r, jp_x_r, jp_y_r;
  logic                    fin_r;
  logic signed [V_W-1:0]   vx_r, vy_r, svx_r, svy_r;
  logic [V_W-1:0]          n_r, sn_r;
  logic signed [D_W-1:0]   dx_r, dy_r, sdx_r, sdy_r;
  logic signed [D_W-1:0]   s_r, px_r, py_r, pr1x_r, pr1y_r;
  logic signed [VX_W-1:0]  plu_x_r, plu_y_r, pld_x_r, pld_y_r;
  logic                    neg_r, proj_sel_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;

  // Vertex buffer
  logic signed [CW-1:0] bx_r [8];
  logic signed [CW-1:0] by_r [8];
  logic [1:0]           deg_r;
  logic                 out_fin_r;

  logic in_acc, out_acc, cfg_wr;
  logic sq_start, sq_busy, sq_done;
  logic [SQ_OUT_W-1:0] sq_root;
  logic [SQ_IN_W-1:0]  radicand;
  logic [SQW-1:0]      sq_wide;
  logic div_start, div_busy, div_done;
  logic signed [ACC_W-1:0] div_num;
  logic [V_W-1:0]          div_den;
  logic signed [Q_W-1:0]   div_quot;

  logic signed [ACC_W-1:0] acc_sum;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [V_W-1:0]   wx, wy;
  logic [V_W-1:0]          m_len;
  logic signed [D_W-1:0]   o_x, o_y;
  logic signed [MW-1:0]    ox, oy, hw_s;
  logic signed [CW-1:0]    pt_x, pt_y;
  logic                    seg2;

  assign pt_x = in_tdata[CW-1:0];
  assign pt_y = in_tdata[2*CW-1:CW];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = (buf_cnt_r != 4'd0);
  assign out_acc    = out_tvalid & out_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & (cfg_paddr == CFG_ADDR_HALF_WIDTH);
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_HALF_WIDTH) ? 32'(hw_r) : 32'd0;

  assign seg2    = (seen_r == SEEN_SEG);
  assign acc_sum = acc_r + ACC_W'(prod_r);
  assign hw_s    = MW'($signed({1'b0, hw_r}));

  // Projection operands: first onto the pending segment, then onto the new one.
  assign wx    = proj_sel_r ? vx_r : svx_r;
  assign wy    = proj_sel_r ? vy_r : svy_r;
  assign m_len = proj_sel_r ? n_r : sn_r;
  assign o_x   = proj_sel_r ? sdx_r : dx_r;
  assign o_y   = proj_sel_r ? sdy_r : dy_r;
  assign ox    = neg_r ? MW'(o_x) : -MW'(o_x);
  assign oy    = neg_r ? MW'(o_y) : -MW'(o_y);

  // The sum of squares clips at the largest positive 64-bit value.
  assign sq_wide  = SQW'($unsigned(acc_sum));
  assign radicand = (sq_wide > SQW'(SQ_LIM)) ? SQ_LIM : SQ_IN_W'(sq_wide);

  assign div_num = (state_r == ST_PB2) ? acc_r : ACC_W'(prod_r);
  assign div_den = (state_r == ST_DX || state_r == ST_DY) ? n_r : m_len;

  pse_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  pse_div #(
    .NUM_W (ACC_W),
    .DEN_W (V_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Shared multiplier operand selection; the product is registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ_A: begin
        mul_a = MW'(vx_r);
        mul_b = MW'(vx_r);
      end
      ST_SQ_B: begin
        mul_a = MW'(vy_r);
        mul_b = MW'(vy_r);
      end
      ST_SQRT: begin
        mul_a = MW'(vy_r);
        mul_b = hw_s;
      end
      ST_DXW: begin
        mul_a = -MW'(vx_r);
        mul_b = hw_s;
      end
      ST_JOINT: begin
        mul_a = MW'(dx_r) - MW'(sdx_r);
        mul_b = MW'(svx_r);
      end
      ST_TA: begin
        mul_a = MW'(dy_r) - MW'(sdy_r);
        mul_b = MW'(svy_r);
      end
      ST_PJ: begin
        mul_a = ox;
        mul_b = MW'(wx);
      end
      ST_PA: begin
        mul_a = oy;
        mul_b = MW'(wy);
      end
      ST_PC: begin
        mul_a = MW'(wx);
        mul_b = MW'(s_r);
      end
      ST_PDW: begin
        mul_a = MW'(wy);
        mul_b = MW'(s_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sq_start  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE:  if (in_acc && seen_r != SEEN_NONE) state_nxt = ST_SQ_A;
      ST_SQ_A:  state_nxt = ST_SQ_B;
      ST_SQ_B:  state_nxt = ST_SQ_C;
      ST_SQ_C: begin
        sq_start  = 1'b1;
        state_nxt = ST_SQRT;
      end
      ST_SQRT:  if (sq_done) state_nxt = (sq_root == '0) ? ST_JOINT : ST_DX;
      ST_DX: begin
        div_start = 1'b1;
        state_nxt = ST_DXW;
      end
      ST_DXW:   if (div_done) state_nxt = ST_DY;
      ST_DY: begin
        div_start = 1'b1;
        state_nxt = ST_DYW;
      end
      ST_DYW:   if (div_done) state_nxt = ST_JOINT;
      ST_JOINT: state_nxt = seg2 ? ST_TA : ST_BUILD;
      ST_TA:    state_nxt = ST_TB;
      ST_TB:    state_nxt = ST_PJ;
      ST_PJ:    state_nxt = (m_len == '0) ? ST_PNEXT : ST_PA;
      ST_PA:    state_nxt = ST_PB;
      ST_PB:    state_nxt = ST_PB2;
      ST_PB2: begin
        div_start = 1'b1;
        state_nxt = ST_PBW;
      end
      ST_PBW:   if (div_done) state_nxt = ST_PC;
      ST_PC:    state_nxt = ST_PD;
      ST_PD: begin
        div_start = 1'b1;
        state_nxt = ST_PDW;
      end
      ST_PDW:   if (div_done) state_nxt = ST_PE;
      ST_PE: begin
        div_start = 1'b1;
        state_nxt = ST_PEW;
      end
      ST_PEW:   if (div_done) state_nxt = ST_PNEXT;
      ST_PNEXT: state_nxt = proj_sel_r ? ST_BUILD : ST_PJ;
      ST_BUILD: if (buf_cnt_r == 4'd0) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Vertex assembly at the joint and at the path end.
  function automatic logic signed [CW-1:0] sat_c(input logic signed [VX_W-1:0] v);
    logic in_rng;
    in_rng = (v[VX_W-1:CW-1] == '0) || (v[VX_W-1:CW-1] == '1);
    if (in_rng) return v[CW-1:0];
    return v[VX_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  logic signed [VX_W-1:0] jx, jy, ex, ey, sdxw, sdyw, dxw, dyw;
  logic signed [VX_W-1:0] up1x, up1y, dn1x, dn1y, up2x, up2y, dn2x, dn2y;
  logic signed [VX_W-1:0] urx, ury, drx, dry, nlux, nluy, nldx, nldy;
  logic signed [VX_W-1:0] fux, fuy, fdx, fdy;

  always_comb begin
    jx   = VX_W'(jp_x_r);
    jy   = VX_W'(jp_y_r);
    ex   = VX_W'(p_x_r);
    ey   = VX_W'(p_y_r);
    sdxw = VX_W'(sdx_r);
    sdyw = VX_W'(sdy_r);
    dxw  = VX_W'(dx_r);
    dyw  = VX_W'(dy_r);
    // On a left turn the down corners take the projection, else the up ones.
    up1x = (seg2 && !neg_r) ? VX_W'(pr1x_r) : '0;
    up1y = (seg2 && !neg_r) ? VX_W'(pr1y_r) : '0;
    dn1x = (seg2 && neg_r)  ? VX_W'(pr1x_r) : '0;
    dn1y = (seg2 && neg_r)  ? VX_W'(pr1y_r) : '0;
    up2x = (seg2 && !neg_r) ? VX_W'(px_r) : '0;
    up2y = (seg2 && !neg_r) ? VX_W'(py_r) : '0;
    dn2x = (seg2 && neg_r)  ? VX_W'(px_r) : '0;
    dn2y = (seg2 && neg_r)  ? VX_W'(py_r) : '0;
    urx  = jx - sdxw + up1x;
    ury  = jy - sdyw + up1y;
    drx  = jx + sdxw + dn1x;
    dry  = jy + sdyw + dn1y;
    nlux = jx - dxw + up2x;
    nluy = jy - dyw + up2y;
    nldx = jx + dxw + dn2x;
    nldy = jy + dyw + dn2y;
    fux  = ex - dxw;
    fuy  = ey - dyw;
    fdx  = ex + dxw;
    fdy  = ey + dyw;
  end

  logic build_go;
  assign build_go = (state_r == ST_BUILD) && (buf_cnt_r == 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      seen_r    <= SEEN_NONE;
      hw_r      <= HW_RESET;
      buf_cnt_r <= 4'd0;
      rd_idx_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) hw_r <= cfg_pwdata[HW_W-1:0];
      if (in_acc && seen_r == SEEN_NONE && !in_tlast) seen_r <= SEEN_ONE;
      if (build_go) begin
        seen_r    <= fin_r ? SEEN_NONE : SEEN_SEG;
        buf_cnt_r <= (seg2 ? 4'd4 : 4'd0) + (fin_r ? 4'd4 : 4'd0);
        rd_idx_r  <= 3'd0;
      end else if (out_acc) begin
        buf_cnt_r <= buf_cnt_r - 4'd1;
        rd_idx_r  <= rd_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          p_x_r <= pt_x;
          p_y_r <= pt_y;
          fin_r <= in_tlast;
          vx_r  <= V_W'(pt_x) - V_W'(jp_x_r);
          vy_r  <= V_W'(pt_y) - V_W'(jp_y_r);
          if (seen_r == SEEN_NONE) begin
            jp_x_r <= pt_x;
            jp_y_r <= pt_y;
          end
        end
      end
      ST_SQ_B: acc_r <= ACC_W'(prod_r);
      ST_SQRT: begin
        if (sq_done) begin
          n_r  <= V_W'(sq_root);
          dx_r <= '0;
          dy_r <= '0;
        end
      end
      ST_DXW:  if (div_done) dx_r <= D_W'(div_quot);
      ST_DYW:  if (div_done) dy_r <= D_W'(div_quot);
      ST_TA:   acc_r <= ACC_W'(prod_r);
      ST_TB: begin
        neg_r      <= acc_sum[ACC_W-1];
        proj_sel_r <= 1'b0;
      end
      ST_PJ: begin
        px_r <= '0;
        py_r <= '0;
      end
      ST_PA:   acc_r <= ACC_W'(prod_r);
      ST_PB:   acc_r <= acc_sum;
      ST_PBW:  if (div_done) s_r <= D_W'(div_quot);
      ST_PDW:  if (div_done) px_r <= D_W'(div_quot);
      ST_PEW:  if (div_done) py_r <= D_W'(div_quot);
      ST_PNEXT: begin
        if (!proj_sel_r) begin
          pr1x_r     <= px_r;
          pr1y_r     <= py_r;
          proj_sel_r <= 1'b1;
        end
      end
      ST_BUILD: begin
        if (buf_cnt_r == 4'd0) begin
          out_fin_r <= fin_r;
          if (seg2) begin
            bx_r[0] <= sat_c(plu_x_r);
            by_r[0] <= sat_c(plu_y_r);
            bx_r[1] <= sat_c(pld_x_r);
            by_r[1] <= sat_c(pld_y_r);
            bx_r[2] <= sat_c(urx);
            by_r[2] <= sat_c(ury);
            bx_r[3] <= sat_c(drx);
            by_r[3] <= sat_c(dry);
            bx_r[4] <= sat_c(nlux);
            by_r[4] <= sat_c(nluy);
            bx_r[5] <= sat_c(nldx);
            by_r[5] <= sat_c(nldy);
            bx_r[6] <= sat_c(fux);
            by_r[6] <= sat_c(fuy);
            bx_r[7] <= sat_c(fdx);
            by_r[7] <= sat_c(fdy);
            deg_r   <= {(n_r == '0), (sn_r == '0)};
          end else begin
            bx_r[0] <= sat_c(nlux);
            by_r[0] <= sat_c(nluy);
            bx_r[1] <= sat_c(nldx);
            by_r[1] <= sat_c(nldy);
            bx_r[2] <= sat_c(fux);
            by_r[2] <= sat_c(fuy);
            bx_r[3] <= sat_c(fdx);
            by_r[3] <= sat_c(fdy);
            deg_r   <= {(n_r == '0), (n_r == '0)};
          end
          if (!fin_r) begin
            plu_x_r <= nlux;
            plu_y_r <= nluy;
            pld_x_r <= nldx;
            pld_y_r <= nldy;
            svx_r   <= vx_r;
            svy_r   <= vy_r;
            sn_r    <= n_r;
            sdx_r   <= dx_r;
            sdy_r   <= dy_r;
            jp_x_r  <= p_x_r;
            jp_y_r  <= p_y_r;
          end
        end
      end
      default: ;
    endcase
  end

  logic run_last;
  assign run_last  = (buf_cnt_r == 4'd1);
  assign out_tdata = TD_W'({by_r[rd_idx_r], bx_r[rd_idx_r]});
  assign out_tuser = {run_last, deg_r[rd_idx_r[2]], rd_idx_r[1:0]};
  assign out_tlast = run_last & out_fin_r;

`ifndef SYNTHESIS
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= 4'd8)
    else $error("vertex buffer count out of range");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sq_busy && div_busy))
    else $error("square root and divider busy together");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[3])
    else $error("strip end without run last");

  a_build_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUILD && buf_cnt_r == 4'd0) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after writing vertices");
`endif

endmodule

// ===== rtl/core/pse_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_sqrt
// Serial integer square root, two radicand bits per cycle, floor result.
// ----------------------------------------------------------------------------
module pse_sqrt import pse_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SQ_IN_W-1:0]  radicand,
  output logic                busy,
  output logic                done,
  output logic [SQ_OUT_W-1:0] root
);

  localparam int REM_W = SQ_OUT_W + 2;
  localparam int CNT_W = $clog2(SQ_OUT_W + 1);

  logic [SQ_IN_W-1:0]  x_r;
  logic [REM_W-1:0]    rem_r;
  logic [SQ_OUT_W-1:0] root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             fits;

  assign rem_sh = {rem_r, x_r[SQ_IN_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SQ_OUT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r <= x_r << 2;
      if (fits) begin
        rem_r  <= REM_W'(rem_sh - trial);
        root_r <= {root_r[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(rem_sh);
        root_r <= {root_r[SQ_OUT_W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/pse_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_div
// Serial signed divider by a positive divisor, one quotient bit per cycle,
// rounding half away from zero.
// ----------------------------------------------------------------------------
module pse_div import pse_pkg::*; #(
  parameter int NUM_W = 53,
  parameter int DEN_W = 25
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic                    done,
  output logic signed [NUM_W+1:0] quot
);

  localparam int QM_W  = NUM_W + 1;
  localparam int CNT_W = $clog2(QM_W + 1);

  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]        den_r;
  logic [DEN_W-1:0]        rem_r;
  logic [QM_W-1:0]         quo_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    busy_r;
  logic                    setup_r;
  logic                    done_r;

  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign mag    = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign rem_sh = {rem_r, quo_r[QM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      setup_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        setup_r <= 1'b1;
      end else if (setup_r) begin
        setup_r <= 1'b0;
        cnt_r   <= CNT_W'(QM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
    end else if (setup_r) begin
      // Adding half the divisor up front turns truncation into rounding.
      quo_r <= QM_W'(mag) + QM_W'(den_r >> 1);
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[QM_W-2:0], fits};
      rem_r <= fits ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = num_r[NUM_W-1] ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule
